// ===== hdl/ecc_pkg.sv =====
// Shared types, constants and calendar tables for the epoch/calendar converter.
package ecc_pkg;

   localparam int unsigned LATENCY     = 8;
   localparam int unsigned UNPACK_LAT  = 7;
   localparam int unsigned PACK_LAT    = 2;

   localparam logic        KIND_PACK   = 1'b0;
   localparam logic        KIND_UNPACK = 1'b1;

   localparam logic [11:0] FIRST_YEAR  = 12'd1970;
   localparam logic [11:0] LAST_YEAR   = 12'd2099;
   localparam logic [31:0] MAX_SECONDS = 32'd4102444799;
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN = 6'd60;

   // Reciprocals for constant division
   localparam logic [22:0] RECIP_675   = 23'd6362914;   // floor(2^32 / 675)
   localparam logic [16:0] RECIP_1461  = 17'd91868;     // ceil(2^27 / 1461)
   localparam logic [17:0] RECIP_3600  = 18'd149131;    // ceil(2^29 / 3600)
   localparam logic [12:0] RECIP_60    = 13'd4370;      // ceil(2^18 / 60)

   typedef struct packed {
      logic        kind;
      logic [31:0] epoch_seconds;
      logic [11:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
      logic [4:0]  hour_in;
      logic [5:0]  minute_in;
      logic [5:0]  second_in;
   } ecc_req_type;

   typedef struct packed {
      logic [31:0] seconds_out;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic        error;
   } ecc_rsp_type;

   // Days before year within a 4-year cycle
   function automatic logic [10:0] days_before_year(input logic [1:0] idx);
      logic [10:0] d;
      case (idx)
         2'd0:    d = 11'd0;
         2'd1:    d = 11'd365;
         2'd2:    d = 11'd730;
         default: d = 11'd1096;
      endcase
      return d;
   endfunction

   // Days before month (month 1 to 12)
   function automatic logic [8:0] days_before_month(input logic leap,
                                                    input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = leap ? 9'd60  : 9'd59;
         4'd4:    d = leap ? 9'd91  : 9'd90;
         4'd5:    d = leap ? 9'd121 : 9'd120;
         4'd6:    d = leap ? 9'd152 : 9'd151;
         4'd7:    d = leap ? 9'd182 : 9'd181;
         4'd8:    d = leap ? 9'd213 : 9'd212;
         4'd9:    d = leap ? 9'd244 : 9'd243;
         4'd10:   d = leap ? 9'd274 : 9'd273;
         4'd11:   d = leap ? 9'd305 : 9'd304;
         4'd12:   d = leap ? 9'd335 : 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Length of month (month 1 to 12)
   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
      logic [4:0] d;
      case (month)
         4'd2:                              d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:           d = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         default:                           d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== hdl/ecc_pack.sv =====
// Two-stage pipeline that packs calendar fields into epoch seconds.
module ecc_pack (
   input  logic                clock,
   input  ecc_pkg::ecc_req_type req_data,
   output ecc_pkg::ecc_rsp_type rsp_data
);
   import ecc_pkg::*;

   logic        leap;
   logic [7:0]  year_ofs;
   logic        bad;
   logic [15:0] days_in;
   logic [16:0] tod_in;
   logic [32:0] day_secs;
   logic [31:0] secs;

   logic [15:0] days_ff;
   logic [16:0] tod_ff;
   logic        err_ff;
   ecc_req_type req_ff;
   ecc_rsp_type rsp_ff;
   ecc_rsp_type rsp_in;

   // Check fields and build day count and time of day
   always_comb begin
      leap     = (req_data.year_in[1:0] == 2'd0);
      year_ofs = 8'(req_data.year_in - FIRST_YEAR);
      bad = (req_data.year_in < FIRST_YEAR) || (req_data.year_in > LAST_YEAR) ||
            (req_data.month_in < 4'd1) || (req_data.month_in > 4'd12) ||
            (req_data.hour_in > 5'd23) || (req_data.minute_in > 6'd59) ||
            (req_data.second_in > 6'd59) || (req_data.day_in == 5'd0) ||
            (req_data.day_in > month_len(leap, req_data.month_in));
      days_in = 16'(16'(year_ofs[7:2]) * 16'(CYCLE_DAYS))
              + 16'(days_before_year(year_ofs[1:0]))
              + 16'(days_before_month(leap, req_data.month_in))
              + 16'(req_data.day_in) - 16'd1;
      tod_in = 17'(17'(req_data.hour_in) * 17'(SECS_PER_HOUR))
             + 17'(17'(req_data.minute_in) * 17'(SECS_PER_MIN))
             + 17'(req_data.second_in);
   end

   always_ff @(posedge clock) begin
      days_ff <= days_in;
      tod_ff  <= tod_in;
      err_ff  <= bad;
      req_ff  <= req_data;
   end

   // Scale days to seconds and assemble the result
   always_comb begin
      day_secs = 33'(days_ff) * 33'(SECS_PER_DAY);
      secs     = day_secs[31:0] + 32'(tod_ff);
      rsp_in   = '0;
      if (err_ff) begin
         rsp_in.error = 1'b1;
      end else begin
         rsp_in.seconds_out = secs;
         rsp_in.year_out    = req_ff.year_in;
         rsp_in.month_out   = req_ff.month_in;
         rsp_in.day_out     = req_ff.day_in;
         rsp_in.hour_out    = req_ff.hour_in;
         rsp_in.minute_out  = req_ff.minute_in;
         rsp_in.second_out  = req_ff.second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/ecc_unpack.sv =====
// Seven-stage pipeline that splits epoch seconds into calendar fields.
module ecc_unpack (
   input  logic                clock,
   input  logic [31:0]         epoch_seconds,
   output ecc_pkg::ecc_rsp_type rsp_data
);
   import ecc_pkg::*;

   // Stage 1: estimate day count
   logic [47:0] q_prod;
   logic [31:0] s1_secs_ff;
   logic        s1_err_ff;
   logic [15:0] s1_q_ff;

   assign q_prod = 48'(epoch_seconds[31:7]) * 48'(RECIP_675);

   always_ff @(posedge clock) begin
      s1_secs_ff <= epoch_seconds;
      s1_err_ff  <= (epoch_seconds > MAX_SECONDS);
      s1_q_ff    <= q_prod[47:32];
   end

   // Stage 2: remainder of the estimate
   logic [32:0] q_secs;
   logic [31:0] s2_secs_ff;
   logic        s2_err_ff;
   logic [15:0] s2_q_ff;
   logic [17:0] s2_r_ff;

   assign q_secs = 33'(s1_q_ff) * 33'(SECS_PER_DAY);

   always_ff @(posedge clock) begin
      s2_secs_ff <= s1_secs_ff;
      s2_err_ff  <= s1_err_ff;
      s2_q_ff    <= s1_q_ff;
      s2_r_ff    <= 18'(s1_secs_ff - q_secs[31:0]);
   end

   // Stage 3: correct the estimate by one day
   logic        fix;
   logic [31:0] s3_secs_ff;
   logic        s3_err_ff;
   logic [15:0] s3_days_ff;
   logic [16:0] s3_rem_ff;

   assign fix = (s2_r_ff >= 18'(SECS_PER_DAY));

   always_ff @(posedge clock) begin
      s3_secs_ff <= s2_secs_ff;
      s3_err_ff  <= s2_err_ff;
      s3_days_ff <= fix ? s2_q_ff + 16'd1 : s2_q_ff;
      s3_rem_ff  <= fix ? 17'(s2_r_ff - 18'(SECS_PER_DAY)) : 17'(s2_r_ff);
   end

   // Stage 4: cycle count and hour
   logic [32:0] cyc_prod;
   logic [34:0] hour_prod;
   logic [31:0] s4_secs_ff;
   logic        s4_err_ff;
   logic [15:0] s4_days_ff;
   logic [16:0] s4_rem_ff;
   logic [5:0]  s4_cyc_ff;
   logic [4:0]  s4_hour_ff;

   assign cyc_prod  = 33'(s3_days_ff) * 33'(RECIP_1461);
   assign hour_prod = 35'(s3_rem_ff) * 35'(RECIP_3600);

   always_ff @(posedge clock) begin
      s4_secs_ff <= s3_secs_ff;
      s4_err_ff  <= s3_err_ff;
      s4_days_ff <= s3_days_ff;
      s4_rem_ff  <= s3_rem_ff;
      s4_cyc_ff  <= cyc_prod[32:27];
      s4_hour_ff <= hour_prod[33:29];
   end

   // Stage 5: day within cycle and seconds within hour
   logic [15:0] cyc_days;
   logic [16:0] hour_secs;
   logic [31:0] s5_secs_ff;
   logic        s5_err_ff;
   logic [5:0]  s5_cyc_ff;
   logic [4:0]  s5_hour_ff;
   logic [10:0] s5_dic_ff;
   logic [11:0] s5_remh_ff;

   assign cyc_days  = 16'(s4_cyc_ff) * 16'(CYCLE_DAYS);
   assign hour_secs = 17'(s4_hour_ff) * 17'(SECS_PER_HOUR);

   always_ff @(posedge clock) begin
      s5_secs_ff <= s4_secs_ff;
      s5_err_ff  <= s4_err_ff;
      s5_cyc_ff  <= s4_cyc_ff;
      s5_hour_ff <= s4_hour_ff;
      s5_dic_ff  <= 11'(s4_days_ff - cyc_days);
      s5_remh_ff <= 12'(s4_rem_ff - hour_secs);
   end

   // Stage 6: year within cycle and minute
   logic [1:0]  yidx;
   logic [24:0] min_prod;
   logic [31:0] s6_secs_ff;
   logic        s6_err_ff;
   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_remh_ff;
   logic [11:0] s6_year_ff;
   logic        s6_leap_ff;
   logic [8:0]  s6_doy_ff;
   logic [5:0]  s6_min_ff;

   always_comb begin
      if (s5_dic_ff >= days_before_year(2'd3)) begin
         yidx = 2'd3;
      end else if (s5_dic_ff >= days_before_year(2'd2)) begin
         yidx = 2'd2;
      end else if (s5_dic_ff >= days_before_year(2'd1)) begin
         yidx = 2'd1;
      end else begin
         yidx = 2'd0;
      end
   end

   assign min_prod = 25'(s5_remh_ff) * 25'(RECIP_60);

   always_ff @(posedge clock) begin
      s6_secs_ff <= s5_secs_ff;
      s6_err_ff  <= s5_err_ff;
      s6_hour_ff <= s5_hour_ff;
      s6_remh_ff <= s5_remh_ff;
      s6_year_ff <= FIRST_YEAR + {4'd0, s5_cyc_ff, 2'd0} + 12'(yidx);
      s6_leap_ff <= (yidx == 2'd2);
      s6_doy_ff  <= 9'(s5_dic_ff - days_before_year(yidx));
      s6_min_ff  <= min_prod[23:18];
   end

   // Stage 7: month search, day and second
   logic [3:0]  month;
   logic [8:0]  day_ofs;
   logic [11:0] min_secs;
   ecc_rsp_type rsp_in;
   ecc_rsp_type rsp_ff;

   always_comb begin
      month = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (s6_doy_ff >= days_before_month(s6_leap_ff, 4'(m))) begin
            month = 4'(m);
         end
      end
      day_ofs  = s6_doy_ff - days_before_month(s6_leap_ff, month);
      min_secs = 12'(s6_min_ff) * 12'(SECS_PER_MIN);
      rsp_in   = '0;
      if (s6_err_ff) begin
         rsp_in.error = 1'b1;
      end else begin
         rsp_in.seconds_out = s6_secs_ff;
         rsp_in.year_out    = s6_year_ff;
         rsp_in.month_out   = month;
         rsp_in.day_out     = 5'(day_ofs + 9'd1);
         rsp_in.hour_out    = s6_hour_ff;
         rsp_in.minute_out  = s6_min_ff;
         rsp_in.second_out  = 6'(s6_remh_ff - min_secs);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/epoch_seconds_calendar_convert.sv =====
// Top level of the epoch seconds / calendar field converter.
//
// Usage: drive req_data and raise start for one cycle per request. busy is
// always low, so a request is taken at every rising edge where start is high.
// req_data.kind selects packing calendar fields into seconds (0) or
// splitting seconds into calendar fields (1).
// Each request yields one result on rsp_data, marked by rsp_strobe for a
// single cycle.
// Throughput is one request per cycle; the depth is set by the seconds
// split path (day divide, remainder, correction, cycle/hour, subtract,
// year/minute, month search) plus the output register.
// Invalid or out-of-range fields give a result with error set and every
// other field zero.
// Reset clears the valid bits of the pipeline; requests in flight are
// dropped. The receiver cannot hold results off and needs none.
module epoch_seconds_calendar_convert (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ecc_pkg::ecc_req_type req_data,
   output logic                 rsp_strobe,
   output ecc_pkg::ecc_rsp_type rsp_data
);
   import ecc_pkg::*;

   localparam int unsigned PAD = UNPACK_LAT - PACK_LAT;

   ecc_rsp_type              pack_rsp;
   ecc_rsp_type              unpack_rsp;
   ecc_rsp_type              pad_ff [PAD];
   logic [UNPACK_LAT-1:0]    kind_ff;
   logic [LATENCY-1:0]       valid_ff;
   logic [LATENCY-1:0]       valid_in;
   ecc_rsp_type              rsp_ff;
   ecc_rsp_type              rsp_in;

   assign busy = 1'b0;

   ecc_pack u_pack (
      .clock    (clock),
      .req_data (req_data),
      .rsp_data (pack_rsp)
   );

   ecc_unpack u_unpack (
      .clock         (clock),
      .epoch_seconds (req_data.epoch_seconds),
      .rsp_data      (unpack_rsp)
   );

   // Advance valid bits with the data
   assign valid_in = {valid_ff[LATENCY-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Align the pack result and the kind with the split path
   always_ff @(posedge clock) begin
      pad_ff[0] <= pack_rsp;
      for (int i = 1; i < PAD; i++) begin
         pad_ff[i] <= pad_ff[i-1];
      end
      kind_ff <= {kind_ff[UNPACK_LAT-2:0], req_data.kind};
   end

   // Select the result by kind
   assign rsp_in = (kind_ff[UNPACK_LAT-1] == KIND_UNPACK) ? unpack_rsp : pad_ff[PAD-1];

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = valid_ff[LATENCY-1];
   assign rsp_data   = rsp_ff;

endmodule

// ===== hdl/ecc_checker.sv =====
// Port-level checker for the epoch/calendar converter, bound to the top level.
module ecc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input ecc_pkg::ecc_rsp_type rsp_data
);
   import ecc_pkg::*;

   // Each request yields one result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##8 rsp_strobe)
      else $error("request without result");

   // No result appears without a request
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 8))
      else $error("result without request");

   // Error results carry zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.error |->
         rsp_data.seconds_out == 32'd0 && rsp_data.year_out == 12'd0 &&
         rsp_data.month_out == 4'd0 && rsp_data.day_out == 5'd0)
      else $error("error result not cleared");

   // Good results stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.error |->
         rsp_data.seconds_out <= MAX_SECONDS && rsp_data.month_out >= 4'd1 &&
         rsp_data.month_out <= 4'd12 && rsp_data.day_out >= 5'd1 &&
         rsp_data.hour_out <= 5'd23 && rsp_data.minute_out <= 6'd59 &&
         rsp_data.second_out <= 6'd59)
      else $error("result field out of range");

endmodule

bind epoch_seconds_calendar_convert ecc_checker u_ecc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
